// ===== src/bitmap_block_allocator_next_fit_macros.svh =====
// Assertion macros for the next-fit bitmap block allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_NEXT_FIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBANF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BBANF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bbanf_pkg.sv =====
// Shared constants and types of the next-fit bitmap block allocator
`timescale 1ns / 1ps
`default_nettype none

package bbanf_pkg;

  // volume geometry
  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BLK_W      = 12;
  localparam int CNT_W      = 13;
  localparam int WADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ST_W       = 3;
  localparam int CFG_IDX_W  = 2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
  localparam logic [ST_W-1:0] ST_RDONLY = 3'd2;
  localparam logic [ST_W-1:0] ST_DOUBLE = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd4;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY    = 2'd2;

  typedef logic [WADDR_W-1:0]   waddr_t;
  typedef logic [WORD_BITS-1:0] word_t;

  // bitmap write port
  typedef struct packed {
    logic   en;
    waddr_t addr;
    word_t  data;
  } map_wr_t;

endpackage

`default_nettype wire

// ===== src/bitmap_block_allocator_next_fit.sv =====
// Top level of the next-fit bitmap block allocator
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in_     | input     | in_valid / in_ready   | in_command, in_block_number
//  out_    | output    | out_valid / out_ready | out_status, out_allocated_block
//  cfg_    | input     | cfg_we                | cfg_addr, cfg_wdata
//
// Allocate: one bitmap word read per cycle through a single priority encoder;
// the scan runs from the hint up to the end of the data area and, after a wrap,
// on from the data start up to the scan start; a wrapped scan may visit the
// hint's word twice, so at most 129 words are visited.
// Free: word read, bit check and write back. A read-only reject goes straight to the result.
// The result sits in an output register; a stalled out_ready holds the next
// item's result in the sequencer until the register empties.
// Reset clears the bitmap valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_allocator_next_fit_macros.svh"

module bitmap_block_allocator_next_fit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // command channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_command,
  input  wire logic [bbanf_pkg::BLK_W-1:0]          in_block_number,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [bbanf_pkg::ST_W-1:0]                out_status,
  output logic [bbanf_pkg::BLK_W-1:0]               out_allocated_block,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [bbanf_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [bbanf_pkg::CNT_W-1:0]          cfg_wdata
);

  localparam int BLK_W   = bbanf_pkg::BLK_W;
  localparam int CNT_W   = bbanf_pkg::CNT_W;
  localparam int BIT_W   = bbanf_pkg::BIT_W;
  localparam int ST_W    = bbanf_pkg::ST_W;
  localparam int WBITS   = bbanf_pkg::WORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        total_r, total_nxt;
  logic [BLK_W-1:0]        dstart_r, dstart_nxt;
  logic                    ronly_r, ronly_nxt;
  logic [BLK_W-1:0]        hint_r, hint_nxt;
  logic [BLK_W-1:0]        blk_r, blk_nxt;
  logic [BLK_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [BLK_W-1:0]        start_r, start_nxt;
  logic                    phase_r, phase_nxt;
  bbanf_pkg::waddr_t       rd_w_r, rd_w_nxt;
  logic                    issue_r, issue_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  bbanf_pkg::waddr_t       chk_w_r, chk_w_nxt;
  logic [ST_W-1:0]         res_status_r, res_status_nxt;
  logic [BLK_W-1:0]        res_block_r, res_block_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;
  logic [BLK_W-1:0]        out_block_r, out_block_nxt;

  logic [CNT_W-1:0]        end_c;
  logic [BLK_W-1:0]        hint_eff;
  logic [BLK_W-1:0]        scan_start;
  logic [CNT_W-1:0]        hi_m1;
  bbanf_pkg::waddr_t       last_w;
  logic [BIT_W-1:0]        hi_b;
  bbanf_pkg::waddr_t       lo_w;
  logic [BIT_W-1:0]        lo_b;
  bbanf_pkg::word_t        rd_data;
  bbanf_pkg::word_t        free_vec;
  logic                    found;
  logic [BIT_W-1:0]        found_idx;
  logic [BLK_W-1:0]        found_blk;
  logic [CNT_W-1:0]        found_next;
  logic                    last_chk;
  logic                    issue_fire;
  bbanf_pkg::waddr_t       rd_addr;
  bbanf_pkg::map_wr_t      map_wr;

  // bitmap store
  bbanf_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (map_wr)
  );

  // end of data area and scan starting point
  assign end_c = (total_r > CNT_W'(bbanf_pkg::MAX_BLOCKS)) ?
                 CNT_W'(bbanf_pkg::MAX_BLOCKS) : total_r;
  assign hint_eff   = (hint_r < dstart_r) ? dstart_r : hint_r;
  assign scan_start = ({1'b0, hint_eff} < end_c) ? hint_eff : dstart_r;

  // segment bounds in word/bit form
  assign hi_m1  = hi_r - CNT_W'(1);
  assign last_w = hi_m1[BLK_W-1:BIT_W];
  assign hi_b   = hi_m1[BIT_W-1:0];
  assign lo_w   = lo_r[BLK_W-1:BIT_W];
  assign lo_b   = lo_r[BIT_W-1:0];

  // free bits of the checked word inside the segment
  always_comb begin
    for (int i = 0; i < WBITS; i++) begin
      free_vec[i] = !rd_data[i]
                    && ((chk_w_r != lo_w) || (BIT_W'(i) >= lo_b))
                    && ((chk_w_r != last_w) || (BIT_W'(i) <= hi_b));
    end
  end

  // lowest free bit
  always_comb begin
    found_idx = '0;
    for (int i = WBITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found_idx = BIT_W'(i);
      end
    end
  end

  assign found      = |free_vec;
  assign found_blk  = {chk_w_r, found_idx};
  assign found_next = {1'b0, found_blk} + CNT_W'(1);
  assign last_chk   = chk_vld_r && (chk_w_r == last_w);
  assign issue_fire = (state_r == S_SCAN) && issue_r && !(chk_vld_r && found);

  assign rd_addr = (state_r == S_FREE_RD) ? blk_r[BLK_W-1:BIT_W] : rd_w_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    dstart_nxt     = dstart_r;
    ronly_nxt      = ronly_r;
    hint_nxt       = hint_r;
    blk_nxt        = blk_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    start_nxt      = start_r;
    phase_nxt      = phase_r;
    rd_w_nxt       = rd_w_r;
    issue_nxt      = issue_r;
    chk_vld_nxt    = 1'b0;
    chk_w_nxt      = chk_w_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    map_wr         = '0;
    in_ready       = (state_r == S_IDLE);

    // register writes
    if (cfg_we) begin
      case (cfg_addr)
        bbanf_pkg::CFG_TOTAL_BLOCKS: total_nxt  = cfg_wdata;
        bbanf_pkg::CFG_DATA_START:   dstart_nxt = cfg_wdata[BLK_W-1:0];
        bbanf_pkg::CFG_READ_ONLY:    ronly_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          blk_nxt       = in_block_number;
          res_block_nxt = '0;
          if (ronly_r) begin
            res_status_nxt = bbanf_pkg::ST_RDONLY;
            state_nxt      = S_RESP;
          end else if (in_command == bbanf_pkg::CMD_FREE) begin
            if (({1'b0, in_block_number} >= end_c) || (in_block_number < dstart_r)) begin
              res_status_nxt = bbanf_pkg::ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FREE_RD;
            end
          end else if ({1'b0, dstart_r} >= end_c) begin
            res_status_nxt = bbanf_pkg::ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            lo_nxt    = scan_start;
            hi_nxt    = end_c;
            start_nxt = scan_start;
            phase_nxt = 1'b0;
            rd_w_nxt  = scan_start[BLK_W-1:BIT_W];
            issue_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read side: one word per cycle up to the segment's last word
        if (issue_fire) begin
          chk_vld_nxt = 1'b1;
          chk_w_nxt   = rd_w_r;
          if (rd_w_r == last_w) begin
            issue_nxt = 1'b0;
          end else begin
            rd_w_nxt = rd_w_r + bbanf_pkg::WADDR_W'(1);
          end
        end
        // check side
        if (chk_vld_r && found) begin
          map_wr.en      = 1'b1;
          map_wr.addr    = chk_w_r;
          map_wr.data    = rd_data | (bbanf_pkg::word_t'(1) << found_idx);
          hint_nxt       = (found_next >= end_c) ? dstart_r : found_next[BLK_W-1:0];
          res_status_nxt = bbanf_pkg::ST_OK;
          res_block_nxt  = found_blk;
          issue_nxt      = 1'b0;
          state_nxt      = S_RESP;
        end else if (last_chk) begin
          if (!phase_r && (start_r > dstart_r)) begin
            // wrap: data start up to the scan start
            lo_nxt    = dstart_r;
            hi_nxt    = {1'b0, start_r};
            phase_nxt = 1'b1;
            rd_w_nxt  = dstart_r[BLK_W-1:BIT_W];
            issue_nxt = 1'b1;
          end else begin
            res_status_nxt = bbanf_pkg::ST_FULL;
            res_block_nxt  = '0;
            state_nxt      = S_RESP;
          end
        end
      end

      S_FREE_RD: begin
        state_nxt = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (!rd_data[blk_r[BIT_W-1:0]]) begin
          res_status_nxt = bbanf_pkg::ST_DOUBLE;
        end else begin
          map_wr.en      = 1'b1;
          map_wr.addr    = blk_r[BLK_W-1:BIT_W];
          map_wr.data    = rd_data & ~(bbanf_pkg::word_t'(1) << blk_r[BIT_W-1:0]);
          res_status_nxt = bbanf_pkg::ST_OK;
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_block_nxt  = res_block_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= CNT_W'(4096);
      dstart_r    <= BLK_W'(1);
      ronly_r     <= 1'b0;
      hint_r      <= '0;
      issue_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      dstart_r    <= dstart_nxt;
      ronly_r     <= ronly_nxt;
      hint_r      <= hint_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r        <= blk_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    start_r      <= start_nxt;
    phase_r      <= phase_nxt;
    rd_w_r       <= rd_w_nxt;
    chk_w_r      <= chk_w_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_allocated_block = out_block_r;

  // checks
  `BBANF_ASSERT_NXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "accepted while busy")
  `BBANF_ASSERT_IMP(a_check_in_scan, chk_vld_r, state_r == S_SCAN, "stray word check")
  `BBANF_ASSERT_IMP(a_fail_no_block, out_valid_r && (out_status_r != bbanf_pkg::ST_OK), out_block_r == '0, "block on failure")

endmodule

`default_nettype wire

// ===== src/bbanf_map.sv =====
// Bitmap word store with per-row valid bits; an unwritten row reads as all free
`timescale 1ns / 1ps
`default_nettype none

module bbanf_map (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bbanf_pkg::waddr_t  rd_addr,
  output bbanf_pkg::word_t        rd_data,
  input  wire bbanf_pkg::map_wr_t wr
);

  bbanf_pkg::word_t                    mem [bbanf_pkg::MAP_WORDS];
  logic [bbanf_pkg::MAP_WORDS-1:0]     row_vld_r;
  bbanf_pkg::word_t                    rdata_r;
  logic                                rvld_r;

  // word array: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[rd_addr];
  end

  // row valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld_r[wr.addr] <= 1'b1;
      end
      rvld_r <= row_vld_r[rd_addr];
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire
